/* rtl/xmbr_pkg.sv */
// shared types and constants for the xmodem block receiver
// used by the front, the command queue, the back and the top level
`timescale 1ns / 1ps

package xmbr_pkg;

	localparam int BLOCK_BYTES = 128;
	// position of the checksum byte: mark, number, complement, then data
	localparam logic [7:0] LAST_POS = 8'(BLOCK_BYTES + 3);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_TIMEOUT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT  = 1'd1;

	localparam logic [15:0] BLOCK_TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] IDLE_TIMEOUT_RESET  = 16'd10000;

	localparam logic [7:0] C_ACK = 8'h06;
	localparam logic [7:0] C_NAK = 8'h15;
	localparam logic [7:0] C_EOT = 8'h04;
	localparam logic [7:0] C_SOH = 8'h01;
	localparam logic [7:0] C_CAN = 8'h18;

	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_START = 2'd1,
		MODE_BYTE  = 2'd2,
		MODE_TICK  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_RETRY = 2'd0,
		ST_GOOD  = 2'd1,
		ST_EOF   = 2'd2,
		ST_ABORT = 2'd3
	} status_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] byte_value;
		logic       hdr_required;
		logic       header_ok;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tx_byte;
		logic [6:0] data_index;
		logic [7:0] data_byte;
		status_t    status;
		logic       last;
	} out_item_t;

	// what the back has to emit for one accepted item
	typedef enum logic [2:0] {
		CMD_TX     = 3'd0,
		CMD_DATA   = 3'd1,
		CMD_STATUS = 3'd2,
		CMD_EOT    = 3'd3,
		CMD_CANCEL = 3'd4
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] value;
		logic [6:0] index;
		status_t    status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

endpackage

/* rtl/xmbr_front.sv */
// front: takes input items and configuration writes, runs the protocol state
// and pushes one command per item that produces results; uses xmbr_pkg
`timescale 1ns / 1ps

module xmbr_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [xmbr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [xmbr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  xmbr_pkg::in_item_t               in_data,
	input  xmbr_pkg::q_status_t              q_status,
	output logic                             push,
	output xmbr_pkg::cmd_t                   push_cmd
);
	import xmbr_pkg::*;

	typedef struct packed {
		logic [7:0]  pending_reply;
		logic [7:0]  last_good;
		logic [7:0]  byte_pos;
		logic        receiving;
		logic        header_wanted;
		logic [7:0]  blk_num;
		logic [7:0]  blk_comp;
		logic [7:0]  sum;
		logic [15:0] blk_timer;
		logic [15:0] idle_timer;
	} rx_state_t;

	localparam rx_state_t RX_RESET = '{pending_reply: C_NAK, default: '0};

	rx_state_t   st_q, st_d;
	logic [15:0] block_timeout_q, idle_timeout_q;
	logic        accept;
	logic        do_judge;
	logic [15:0] blk_timer_inc;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_timeout_q <= BLOCK_TIMEOUT_RESET;
			idle_timeout_q  <= IDLE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_TIMEOUT: block_timeout_q <= cfg_data;
				CFG_IDLE_TIMEOUT:  idle_timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign blk_timer_inc = (st_q.blk_timer == 16'hFFFF) ? st_q.blk_timer
		: st_q.blk_timer + 16'd1;

	always_comb begin
		st_d     = st_q;
		push     = 1'b0;
		push_cmd = '0;
		do_judge = 1'b0;
		if (accept) begin
			unique case (in_data.mode)
				MODE_INIT: begin
					st_d.pending_reply = C_NAK;
					st_d.last_good     = 8'd0;
					st_d.receiving     = 1'b0;
					st_d.byte_pos      = 8'd0;
				end
				MODE_START: begin
					push = 1'b1;
					if (!in_data.hdr_required && st_q.idle_timer >= idle_timeout_q) begin
						st_d.receiving  = 1'b0;
						push_cmd.op     = CMD_STATUS;
						push_cmd.status = ST_ABORT;
					end else begin
						push_cmd.op        = CMD_TX;
						push_cmd.value     = st_q.pending_reply;
						st_d.pending_reply = C_NAK;
						st_d.receiving     = 1'b1;
						st_d.header_wanted = in_data.hdr_required;
						st_d.byte_pos      = 8'd0;
						st_d.sum           = 8'd0;
						st_d.blk_timer     = 16'd0;
					end
				end
				MODE_BYTE: begin
					if (st_q.receiving) begin
						priority if (st_q.byte_pos == 8'd0) begin
							if (in_data.byte_value == C_EOT) begin
								push           = 1'b1;
								push_cmd.op    = CMD_EOT;
								st_d.receiving = 1'b0;
							end else if (in_data.byte_value != C_SOH) begin
								push            = 1'b1;
								push_cmd.op     = CMD_STATUS;
								push_cmd.status = ST_RETRY;
								st_d.receiving  = 1'b0;
							end else begin
								st_d.byte_pos = 8'd1;
							end
						end else if (st_q.byte_pos == 8'd1) begin
							st_d.blk_num  = in_data.byte_value;
							st_d.byte_pos = 8'd2;
						end else if (st_q.byte_pos == 8'd2) begin
							st_d.blk_comp = in_data.byte_value;
							st_d.byte_pos = 8'd3;
						end else if (st_q.byte_pos < LAST_POS) begin
							push           = 1'b1;
							push_cmd.op    = CMD_DATA;
							push_cmd.value = in_data.byte_value;
							push_cmd.index = 7'(st_q.byte_pos - 8'd3);
							st_d.sum       = st_q.sum + in_data.byte_value;
							st_d.byte_pos  = st_q.byte_pos + 8'd1;
						end else begin
							// checksum byte: the sum of data minus checksum must come to zero
							st_d.sum = st_q.sum - in_data.byte_value;
							do_judge = 1'b1;
						end
					end
				end
				MODE_TICK: begin
					if (st_q.idle_timer != 16'hFFFF)
						st_d.idle_timer = st_q.idle_timer + 16'd1;
					if (st_q.receiving) begin
						st_d.blk_timer = blk_timer_inc;
						if (blk_timer_inc >= block_timeout_q) begin
							if (st_q.byte_pos == 8'd0) begin
								push            = 1'b1;
								push_cmd.op     = CMD_STATUS;
								push_cmd.status = ST_RETRY;
								st_d.receiving  = 1'b0;
							end else begin
								// bytes not yet received count as zero
								if (st_q.byte_pos <= 8'd1)
									st_d.blk_num = 8'd0;
								if (st_q.byte_pos <= 8'd2)
									st_d.blk_comp = 8'd0;
								do_judge = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase

			if (do_judge) begin
				st_d.receiving = 1'b0;
				push           = 1'b1;
				push_cmd.op    = CMD_STATUS;
				priority if (st_d.blk_num != ~st_d.blk_comp) begin
					push_cmd.status = ST_RETRY;
				end else if (st_d.blk_num == st_q.last_good) begin
					// repeat of the last good block: acknowledge it again
					st_d.pending_reply = C_ACK;
					push_cmd.status    = ST_RETRY;
				end else if (st_d.blk_num != st_q.last_good + 8'd1) begin
					push_cmd.status = ST_RETRY;
				end else if (st_d.sum != 8'd0) begin
					push_cmd.status = ST_RETRY;
				end else if (st_q.header_wanted && !in_data.header_ok) begin
					push_cmd.op = CMD_CANCEL;
				end else begin
					st_d.last_good     = st_d.blk_num;
					st_d.pending_reply = C_ACK;
					st_d.idle_timer    = 16'd0;
					push_cmd.status    = ST_GOOD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= RX_RESET;
		end else begin
			st_q <= st_d;
		end
	end

endmodule

/* rtl/xmbr_queue.sv */
// short command queue between the front and the back
// register array with read and write pointers; uses xmbr_pkg
`timescale 1ns / 1ps

module xmbr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  xmbr_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output xmbr_pkg::cmd_t      head,
	output xmbr_pkg::q_status_t q_status
);
	import xmbr_pkg::*;

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wptr_q, rptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign head              = mem_q[rptr_q];
	assign q_status.full     = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign q_status.nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/xmbr_back.sv */
// back: expands each queued command into one to four result transactions
// and holds them in the output register; uses xmbr_pkg
`timescale 1ns / 1ps

module xmbr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  xmbr_pkg::cmd_t      head,
	input  xmbr_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output xmbr_pkg::out_item_t out_data
);
	import xmbr_pkg::*;

	logic [1:0] step_q;
	logic [1:0] last_step;
	logic       load;
	logic       out_valid_q;
	out_item_t  out_q;
	out_item_t  res;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign load = q_status.nonempty && (!out_valid_q || !out_stall);
	assign pop  = load && (step_q == last_step);

	always_comb begin
		res       = '0;
		last_step = 2'd0;
		unique case (head.op)
			CMD_TX: begin
				res.kind    = KIND_TX;
				res.tx_byte = head.value;
			end
			CMD_DATA: begin
				res.kind       = KIND_DATA;
				res.data_index = head.index;
				res.data_byte  = head.value;
			end
			CMD_STATUS: begin
				res.kind   = KIND_STATUS;
				res.status = head.status;
			end
			CMD_EOT: begin
				// two acks then end of file
				last_step = 2'd2;
				if (step_q == 2'd2) begin
					res.kind   = KIND_STATUS;
					res.status = ST_EOF;
				end else begin
					res.kind    = KIND_TX;
					res.tx_byte = C_ACK;
				end
			end
			CMD_CANCEL: begin
				// three cancels then abort
				last_step = 2'd3;
				if (step_q == 2'd3) begin
					res.kind   = KIND_STATUS;
					res.status = ST_ABORT;
				end else begin
					res.kind    = KIND_TX;
					res.tx_byte = C_CAN;
				end
			end
			default: ;
		endcase
		res.last = (step_q == last_step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				step_q <= 2'd0;
			else if (load)
				step_q <= step_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= res;
	end

endmodule

/* rtl/xmodem_block_receiver_core.sv */
// top level of the xmodem block receiver: front, command queue and back
// depends on xmbr_pkg, xmbr_front, xmbr_queue and xmbr_back
//
//   channel   direction  handshake                 payload
//   in        in         in_valid / in_stall       in_item_t
//   out       out        out_valid / out_stall     out_item_t
//   cfg       in         cfg_we                    cfg_index, cfg_data
//
// one input item is taken per cycle while the command queue has room
// results leave the output register one per cycle unless out_stall holds them;
// an end of file gives three results there and a cancelled block four
// the four-entry command queue lets the input side run while the output is stalled
// reset clears the protocol state and loads the default timeouts at once
`timescale 1ns / 1ps

module xmodem_block_receiver_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [xmbr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [xmbr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  xmbr_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output xmbr_pkg::out_item_t              out_data
);
	import xmbr_pkg::*;

	logic      push, pop;
	cmd_t      push_cmd, head;
	q_status_t q_status;

	xmbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_status  (q_status),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	xmbr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	xmbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* tb/sv/xmodem_block_receiver_checker.sv */
// result checker for the xmodem block receiver: watches the config port and both channels,
// predicts the results of every input transaction and compares them in order
// depends on xmbr_pkg
`timescale 1ns / 1ps

module xmodem_block_receiver_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [xmbr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [xmbr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  xmbr_pkg::in_item_t               in_data,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  xmbr_pkg::out_item_t              out_data,
	output int                               fails,
	output int                               pending
);
	import xmbr_pkg::*;

	logic [15:0] blk_limit;
	logic [15:0] idle_limit;
	logic [7:0]  reply_code;
	logic [7:0]  good_blk;
	logic [7:0]  pos;
	logic        rx_open;
	logic        hdr_wanted;
	logic [7:0]  blk_num;
	logic [7:0]  blk_cmp;
	logic [7:0]  chk_sum;
	logic [15:0] blk_ticks;
	logic [15:0] idle_ticks;

	out_item_t receiver_results_q[$];

	task automatic add_result(input kind_t k, input logic [7:0] tx, input logic [6:0] idx,
			input logic [7:0] d, input status_t st);
		out_item_t r;
		r.kind       = k;
		r.tx_byte    = tx;
		r.data_index = idx;
		r.data_byte  = d;
		r.status     = st;
		r.last       = 1'b0;
		receiver_results_q.push_back(r);
	endtask

	task automatic add_status(input status_t st);
		add_result(KIND_STATUS, 8'h00, 7'd0, 8'h00, st);
	endtask

	task automatic add_tx(input logic [7:0] code);
		add_result(KIND_TX, code, 7'd0, 8'h00, ST_RETRY);
	endtask

	task automatic judge_block(input logic hdr_ok);
		rx_open = 1'b0;
		if (blk_num != ~blk_cmp) begin
			add_status(ST_RETRY);
		end else if (blk_num == good_blk) begin
			// repeat of the last good block: acknowledge it again
			reply_code = C_ACK;
			add_status(ST_RETRY);
		end else if (blk_num != good_blk + 8'd1) begin
			add_status(ST_RETRY);
		end else if (chk_sum != 8'd0) begin
			add_status(ST_RETRY);
		end else if (hdr_wanted && !hdr_ok) begin
			add_tx(C_CAN);
			add_tx(C_CAN);
			add_tx(C_CAN);
			add_status(ST_ABORT);
		end else begin
			good_blk   = blk_num;
			reply_code = C_ACK;
			idle_ticks = 16'd0;
			add_status(ST_GOOD);
		end
	endtask

	task automatic take_byte(input logic [7:0] ch, input logic hdr_ok);
		logic [7:0] idx;
		if (pos == 8'd0) begin
			if (ch == C_EOT) begin
				add_tx(C_ACK);
				add_tx(C_ACK);
				rx_open = 1'b0;
				add_status(ST_EOF);
			end else if (ch != C_SOH) begin
				rx_open = 1'b0;
				add_status(ST_RETRY);
			end else begin
				pos = 8'd1;
			end
		end else if (pos == 8'd1) begin
			blk_num = ch;
			pos     = 8'd2;
		end else if (pos == 8'd2) begin
			blk_cmp = ch;
			pos     = 8'd3;
		end else if (pos < LAST_POS) begin
			idx     = pos - 8'd3;
			chk_sum = chk_sum + ch;
			pos     = pos + 8'd1;
			add_result(KIND_DATA, 8'h00, idx[6:0], ch, ST_RETRY);
		end else begin
			chk_sum = chk_sum - ch;
			judge_block(hdr_ok);
		end
	endtask

	task automatic predict_item(input in_item_t it);
		int        n_prior;
		out_item_t r;
		n_prior = receiver_results_q.size();
		case (it.mode)
			MODE_INIT: begin
				reply_code = C_NAK;
				good_blk   = 8'd0;
				rx_open    = 1'b0;
				pos        = 8'd0;
			end
			MODE_START: begin
				if (!it.hdr_required && idle_ticks >= idle_limit) begin
					rx_open = 1'b0;
					add_status(ST_ABORT);
				end else begin
					add_tx(reply_code);
					reply_code = C_NAK;
					rx_open    = 1'b1;
					hdr_wanted = it.hdr_required;
					pos        = 8'd0;
					chk_sum    = 8'd0;
					blk_ticks  = 16'd0;
				end
			end
			MODE_BYTE: begin
				if (rx_open)
					take_byte(it.byte_value, it.header_ok);
			end
			default: begin
				if (idle_ticks != 16'hffff)
					idle_ticks = idle_ticks + 16'd1;
				if (rx_open) begin
					if (blk_ticks != 16'hffff)
						blk_ticks = blk_ticks + 16'd1;
					if (blk_ticks >= blk_limit) begin
						// out of time: missing bytes count as zero
						if (pos == 8'd0) begin
							rx_open = 1'b0;
							add_status(ST_RETRY);
						end else begin
							if (pos <= 8'd1)
								blk_num = 8'd0;
							if (pos <= 8'd2)
								blk_cmp = 8'd0;
							judge_block(it.header_ok);
						end
					end
				end
			end
		endcase
		if (receiver_results_q.size() > n_prior) begin
			r = receiver_results_q.pop_back();
			r.last = 1'b1;
			receiver_results_q.push_back(r);
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (receiver_results_q.size() == 0) begin
			$error("unexpected result transaction: %h", got);
			fails++;
		end else begin
			want = receiver_results_q.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind expected %0d got %0d", want.kind, got.kind);
				fails++;
			end
			if (got.tx_byte !== want.tx_byte) begin
				$error("tx_byte expected %h got %h", want.tx_byte, got.tx_byte);
				fails++;
			end
			if (got.data_index !== want.data_index) begin
				$error("data_index expected %0d got %0d", want.data_index, got.data_index);
				fails++;
			end
			if (got.data_byte !== want.data_byte) begin
				$error("data_byte expected %h got %h", want.data_byte, got.data_byte);
				fails++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d got %0d", want.status, got.status);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0d got %0d", want.last, got.last);
				fails++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_limit  = BLOCK_TIMEOUT_RESET;
			idle_limit = IDLE_TIMEOUT_RESET;
			reply_code = C_NAK;
			good_blk   = 8'd0;
			pos        = 8'd0;
			rx_open    = 1'b0;
			hdr_wanted = 1'b0;
			blk_num    = 8'd0;
			blk_cmp    = 8'd0;
			chk_sum    = 8'd0;
			blk_ticks  = 16'd0;
			idle_ticks = 16'd0;
			receiver_results_q.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BLOCK_TIMEOUT: blk_limit  = cfg_data;
					CFG_IDLE_TIMEOUT:  idle_limit = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_item(in_data);
			if (out_valid && !out_stall)
				check_result(out_data);
			pending = receiver_results_q.size();
		end
	end

endmodule

/* tb/sv/xmodem_block_receiver_core_tb.sv */
// testbench top for the xmodem block receiver: clock, reset, config writes,
// directed and random transactions, random output stalls and the verdict
// depends on xmbr_pkg, xmodem_block_receiver_core and xmodem_block_receiver_checker
`timescale 1ns / 1ps

module xmodem_block_receiver_core_tb;
	import xmbr_pkg::*;

	localparam int HOLD_CYCLES   = 160;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 20000;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	out_item_t              out_data;

	int fails;
	int pending;
	int lost;
	int sent;
	int hold_left;
	bit calm;
	bit hold_req;
	bit hold_done;

	// rough view of the block's state, only to steer the stimulus
	logic [7:0]  good_guess;
	int          idle_guess;
	logic [15:0] blk_to;
	logic [15:0] idle_to;

	always #4 clk = ~clk;

	xmodem_block_receiver_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	xmodem_block_receiver_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		#2_000_000;
		$display("FAIL xmodem_block_receiver_core");
		$finish;
	end

	// output side: random stalls, plus one long hold-off to back the block up
	initial begin
		out_stall <= 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 14);
			end
		end
	end

	task automatic send(input mode_t m, input logic [7:0] b, input logic eh, input logic ho);
		in_item_t it;
		it.mode         = m;
		it.byte_value   = b;
		it.hdr_required = eh;
		it.header_ok    = ho;
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (m == MODE_TICK)
			idle_guess++;
		if (m == MODE_INIT)
			good_guess = 8'd0;
	endtask

	task automatic send_noise();
		send(mode_t'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (pending != 0) begin
			$error("results never arrived: %0d outstanding", pending);
			lost++;
		end
		// ticks and ignored bytes cause no result, so give the pipe time to empty
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeouts(input logic [15:0] blk, input logic [15:0] idle);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BLOCK_TIMEOUT;
		cfg_data  <= blk;
		@(posedge clk);
		cfg_index <= CFG_IDLE_TIMEOUT;
		cfg_data  <= idle;
		@(posedge clk);
		cfg_we <= 1'b0;
		blk_to  = blk;
		idle_to = idle;
	endtask

	// one block: mostly well formed with random content, some broken on purpose
	task automatic send_block(input bit want_full, input bit by_timeout);
		logic       eh;
		logic       ho;
		logic       good;
		logic [7:0] num;
		logic [7:0] cmp;
		logic [7:0] b;
		logic [7:0] sum;
		int         f;
		int         stage;
		int         n_data;
		eh   = ($urandom_range(3) == 0);
		ho   = eh ? ($urandom_range(3) != 0) : 1'($urandom_range(1));
		good = eh || (idle_guess < idle_to);
		send(MODE_START, 8'($urandom_range(255)), eh, 1'($urandom_range(1)));
		f = $urandom_range(99);
		if (f < 6) begin
			send(MODE_BYTE, C_EOT, 1'($urandom_range(1)), 1'($urandom_range(1)));
			return;
		end
		if (f < 12) begin
			send(MODE_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)), ho);
			return;
		end
		send(MODE_BYTE, C_SOH, 1'($urandom_range(1)), ho);
		f   = $urandom_range(99);
		num = good_guess + 8'd1;
		if (f < 10)
			num = good_guess;
		else if (f < 18)
			num = 8'($urandom_range(255));
		if (num != good_guess + 8'd1)
			good = 1'b0;
		if (want_full || $urandom_range(9) >= 2)
			stage = 2;
		else
			stage = $urandom_range(1);
		if (stage >= 1)
			send(MODE_BYTE, num, 1'($urandom_range(1)), ho);
		if (stage == 2) begin
			cmp = ~num;
			if ($urandom_range(99) < 8)
				cmp = cmp ^ (8'd1 << $urandom_range(7));
			if (cmp != ~num)
				good = 1'b0;
			send(MODE_BYTE, cmp, 1'($urandom_range(1)), ho);
			n_data = want_full ? BLOCK_BYTES : $urandom_range(6);
			sum    = 8'd0;
			for (int i = 0; i < n_data; i++) begin
				b = 8'($urandom_range(255));
				if (!want_full && i == n_data - 1 && $urandom_range(9) != 0)
					b = 8'd0 - sum;
				sum = sum + b;
				send(MODE_BYTE, b, 1'($urandom_range(1)), ho);
			end
			if (want_full) begin
				b = sum;
				if ($urandom_range(9) == 0)
					b = sum + 8'($urandom_range(255, 1));
				if (b != sum)
					good = 1'b0;
				send(MODE_BYTE, b, 1'($urandom_range(1)), ho);
			end else if (sum != 8'd0) begin
				good = 1'b0;
			end
		end else begin
			good = 1'b0;
		end
		if (!want_full) begin
			if (by_timeout)
				repeat (int'(blk_to) + $urandom_range(1))
					send(MODE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), ho);
			else
				good = 1'b0;
		end
		if (good && !(eh && !ho)) begin
			good_guess = num;
			idle_guess = 0;
		end
	endtask

	task automatic run_phase(input logic [15:0] blk, input logic [15:0] idle, input int budget,
			input int full_pct, input bit quiet, input bit pressure);
		int first;
		int r;
		drain();
		set_timeouts(blk, idle);
		calm  = quiet;
		first = sent;
		if (pressure) begin
			hold_req = 1'b1;
			send_block(1'b1, 1'b0);
		end
		while (sent - first < budget) begin
			r = $urandom_range(99);
			if (r < 15)
				repeat ($urandom_range(4, 1)) send_noise();
			else if (r < 20)
				send(MODE_INIT, 8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else
				send_block($urandom_range(99) < full_pct, blk <= 16'd8);
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_BLOCK_TIMEOUT;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		in_data    <= '0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		lost       = 0;
		sent       = 0;
		good_guess = 8'd0;
		idle_guess = 0;
		blk_to     = BLOCK_TIMEOUT_RESET;
		idle_to    = IDLE_TIMEOUT_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every single tick closes an open block
		set_timeouts(16'd1, 16'hffff);
		send(MODE_INIT, 8'h00, 1'b0, 1'b0);
		send(MODE_BYTE, 8'hff, 1'b1, 1'b1);     // no block open, ignored
		send(MODE_TICK, 8'h00, 1'b0, 1'b0);
		send(MODE_START, 8'h00, 1'b0, 1'b0);
		send(MODE_BYTE, C_EOT, 1'b0, 1'b0);      // end of file
		send(MODE_START, 8'hff, 1'b0, 1'b1);
		send(MODE_BYTE, 8'h00, 1'b0, 1'b0);      // bad mark
		send(MODE_START, 8'h00, 1'b1, 1'b0);
		send(MODE_BYTE, C_SOH, 1'b0, 1'b0);
		send(MODE_BYTE, 8'h01, 1'b0, 1'b0);
		send(MODE_BYTE, 8'hfe, 1'b0, 1'b0);
		send(MODE_BYTE, 8'hff, 1'b0, 1'b0);
		send(MODE_BYTE, 8'h01, 1'b0, 1'b0);
		send(MODE_TICK, 8'hff, 1'b1, 1'b0);     // header refused, cancel
		send(MODE_START, 8'h00, 1'b0, 1'b0);
		send(MODE_BYTE, C_SOH, 1'b1, 1'b1);
		send(MODE_BYTE, 8'h01, 1'b1, 1'b1);
		send(MODE_BYTE, 8'hfe, 1'b1, 1'b1);
		send(MODE_TICK, 8'h00, 1'b0, 1'b0);     // good block
		send(MODE_START, 8'h00, 1'b0, 1'b0);
		send(MODE_BYTE, C_SOH, 1'b0, 1'b0);
		send(MODE_BYTE, 8'h01, 1'b0, 1'b0);
		send(MODE_BYTE, 8'hfe, 1'b0, 1'b0);
		send(MODE_TICK, 8'h00, 1'b0, 1'b1);     // same block again
		send(MODE_START, 8'h00, 1'b0, 1'b0);
		send(MODE_TICK, 8'h00, 1'b0, 1'b0);     // timeout before the mark
		send(MODE_START, 8'h00, 1'b0, 1'b0);
		send(MODE_BYTE, C_SOH, 1'b0, 1'b0);
		send(MODE_TICK, 8'h00, 1'b0, 1'b1);     // timeout before the number
		send(MODE_INIT, 8'h00, 1'b0, 1'b0);

		run_phase(16'd1, 16'hffff, 30, 0, 1'b0, 1'b0);
		run_phase(BLOCK_TIMEOUT_RESET, IDLE_TIMEOUT_RESET, 20, 0, 1'b0, 1'b1);
		run_phase(16'd1, 16'd1, 30, 0, 1'b0, 1'b0);
		run_phase(16'd4, 16'd30, 50, 0, 1'b1, 1'b0);
		run_phase(16'hffff, 16'hffff, 25, 20, 1'b0, 1'b0);
		run_phase(16'd3, 16'd6, 40, 0, 1'b0, 1'b0);
		run_phase(16'hffff, 16'd1, 20, 0, 1'b0, 1'b0);
		drain();

		if (fails == 0 && lost == 0 && pending == 0)
			$display("PASS xmodem_block_receiver_core");
		else
			$display("FAIL xmodem_block_receiver_core");
		$finish;
	end

endmodule
